// File: hdl/pol_pkg.sv
// Shared types and codes for the positional ordered list.
package pol_pkg;

    localparam int POS_W  = 8;
    localparam int DATA_W = 32;

    localparam logic [2:0] REQ_INS_POS  = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD = 3'd1;
    localparam logic [2:0] REQ_INS_TAIL = 3'd2;
    localparam logic [2:0] REQ_DELETE   = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;
    localparam logic [2:0] REQ_LOCATE   = 3'd5;
    localparam logic [2:0] REQ_CLEAR    = 3'd6;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BADPOS = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

// File: hdl/positional_ordered_list_top.sv
// Top level of the positional ordered list: sequencer plus a ring of entry cells.
//
// Usage: a request arrives as one transfer on the s_axis group (tuser holds the
// request kind, tdata the position and value); each request gives exactly one
// result transfer on the m_axis group (tuser holds the status, tdata the read
// value, found position, list length and empty flag).
// Inserts, clears, unused codes, bad positions and a locate on an empty list
// finish at once: the result register loads on the edge that takes the request
// when the output is free (else the result is parked), and the sequencer stays
// idle for the next request unless a stalled receiver holds the output.
// A valid read or delete and a locate on a non-empty list rotate the whole ring
// of CAPACITY cells once past the head cell in the scan state, then close in the
// finish state, where a delete shifts the later entries down and the result is
// registered or parked.
// Reset clears the entry count, the sequencer and the output valid; entry cells
// are not cleared. A stalled receiver holds the output register; one further
// result is parked behind it and no new request is taken until it moves out.
module positional_ordered_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // read_value[31:0], found_position[36:32],
                                        // list_length[41:37], is_empty[42], zero[47:43]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import pol_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_cmd_t         cell_cmd;
    logic [IDX_W-1:0]  cell_idx;
    logic [DATA_W-1:0] cell_value [CAPACITY];

    pol_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cell_cmd      (cell_cmd),
        .cell_idx      (cell_idx),
        .head_value    (cell_value[0])
    );

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        pol_cell #(
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .idx         (cell_idx),
            .left_value  (cell_value[(k + CAPACITY - 1) % CAPACITY]),
            .right_value (cell_value[(k + 1) % CAPACITY]),
            .value       (cell_value[k])
        );
    end

endmodule

// File: hdl/pol_cell.sv
// One list entry cell: hold, shift from a neighbor, or load a new value.
module pol_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  pol_pkg::cell_cmd_t        cmd,
    input  logic [IDX_W-1:0]          idx,
    input  logic [pol_pkg::DATA_W-1:0] left_value,
    input  logic [pol_pkg::DATA_W-1:0] right_value,
    output logic [pol_pkg::DATA_W-1:0] value
);
    import pol_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (MY_IDX > idx)
                begin
                    value_next = left_value;
                end
                else if (MY_IDX == idx)
                begin
                    value_next = cmd.data;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= idx)
                begin
                    value_next = right_value;
                end
            end
            CELL_ROTATE:
            begin
                value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: hdl/pol_ctrl.sv
// Request sequencer, entry count and result registers of the ordered list.
module pol_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,
    input  logic [2:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [47:0]                m_axis_tdata,
    output logic [1:0]                 m_axis_tuser,
    output pol_pkg::cell_cmd_t         cell_cmd,
    output logic [IDX_W-1:0]           cell_idx,
    input  logic [pol_pkg::DATA_W-1:0] head_value
);
    import pol_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    logic [2:0]        req_reg, req_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] rval_reg, rval_next;
    logic [CNT_W-1:0]  found_reg, found_next;

    logic [1:0]        out_status_reg, pend_status_reg;
    logic [DATA_W-1:0] out_rval_reg, pend_rval_reg;
    logic [4:0]        out_found_reg, pend_found_reg;
    logic [4:0]        out_len_reg, pend_len_reg;
    logic              out_empty_reg, pend_empty_reg;

    logic              accept;
    logic [2:0]        req_in;
    logic [POS_W-1:0]  pos_in;
    logic [DATA_W-1:0] val_in;
    logic [CMP_W-1:0]  pos_ext, cnt_ext;
    logic              pos_ok_ins, pos_ok_rd, full;
    logic [IDX_W-1:0]  pos_idx;
    logic              slot_free;

    logic              res_fire;
    logic [1:0]        res_status;
    logic [DATA_W-1:0] res_rval;
    logic [CNT_W-1:0]  res_found;
    logic [CNT_W+4:0]  found_wide, len_wide;

    assign req_in     = s_axis_tuser;
    assign pos_in     = s_axis_tdata[7:0];
    assign val_in     = s_axis_tdata[39:8];
    assign accept     = s_axis_tvalid && (state_reg == S_IDLE);
    assign pos_ext    = CMP_W'(pos_in);
    assign cnt_ext    = CMP_W'(cnt_reg);
    assign pos_ok_ins = (pos_in != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign pos_ok_rd  = (pos_in != '0) && (pos_ext <= cnt_ext);
    assign full       = (cnt_reg == FULL_CNT);
    assign pos_idx    = IDX_W'(pos_in - 8'd1);
    assign slot_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        req_next      = req_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        rval_next     = rval_reg;
        found_next    = found_reg;
        cell_cmd.op   = CELL_HOLD;
        cell_cmd.data = val_in;
        cell_idx      = pos_idx;
        res_fire      = 1'b0;
        res_status    = STATUS_OK;
        res_rval      = '0;
        res_found     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_in;
                    pos_next   = pos_idx;
                    val_next   = val_in;
                    rval_next  = '0;
                    found_next = '0;
                    case (req_in)
                        REQ_INS_POS, REQ_INS_HEAD, REQ_INS_TAIL:
                        begin
                            res_fire = 1'b1;
                            if (req_in == REQ_INS_HEAD)
                            begin
                                cell_idx = '0;
                            end
                            else if (req_in == REQ_INS_TAIL)
                            begin
                                cell_idx = cnt_reg[IDX_W-1:0];
                            end
                            if (req_in == REQ_INS_POS && !pos_ok_ins)
                            begin
                                res_status = STATUS_BADPOS;
                            end
                            else if (full)
                            begin
                                res_status = STATUS_FULL;
                            end
                            else
                            begin
                                cell_cmd.op = CELL_INSERT;
                                cnt_next    = cnt_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE, REQ_READ:
                        begin
                            if (!pos_ok_rd)
                            begin
                                res_fire   = 1'b1;
                                res_status = STATUS_BADPOS;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                step_next  = '0;
                            end
                        end
                        REQ_LOCATE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_fire = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                step_next  = '0;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cnt_next = '0;
                            res_fire = 1'b1;
                        end
                        default:
                        begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cell_cmd.op = CELL_ROTATE;
                if ((req_reg == REQ_DELETE || req_reg == REQ_READ) && step_reg == pos_reg)
                begin
                    rval_next = head_value;
                end
                if (req_reg == REQ_LOCATE && found_reg == '0
                    && CNT_W'(step_reg) < cnt_reg && head_value == val_reg)
                begin
                    found_next = CNT_W'(step_reg) + CNT_W'(1);
                end
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_FIN:
            begin
                if (req_reg == REQ_DELETE)
                begin
                    cell_cmd.op = CELL_DELETE;
                    cell_idx    = pos_reg;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                res_fire  = 1'b1;
                res_rval  = rval_reg;
                res_found = found_reg;
            end
            S_WAIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_fire)
        begin
            state_next = slot_free ? S_IDLE : S_WAIT;
        end
    end

    assign found_wide = {5'd0, res_found};
    assign len_wide   = {5'd0, cnt_next};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((res_fire || state_reg == S_WAIT) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        rval_reg  <= rval_next;
        found_reg <= found_next;
        if (res_fire && slot_free)
        begin
            out_status_reg <= res_status;
            out_rval_reg   <= res_rval;
            out_found_reg  <= found_wide[4:0];
            out_len_reg    <= len_wide[4:0];
            out_empty_reg  <= (cnt_next == '0);
        end
        else if (res_fire)
        begin
            pend_status_reg <= res_status;
            pend_rval_reg   <= res_rval;
            pend_found_reg  <= found_wide[4:0];
            pend_len_reg    <= len_wide[4:0];
            pend_empty_reg  <= (cnt_next == '0);
        end
        else if (state_reg == S_WAIT && slot_free)
        begin
            out_status_reg <= pend_status_reg;
            out_rval_reg   <= pend_rval_reg;
            out_found_reg  <= pend_found_reg;
            out_len_reg    <= pend_len_reg;
            out_empty_reg  <= pend_empty_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {5'd0, out_empty_reg, out_len_reg, out_found_reg, out_rval_reg};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && step_reg != LAST_STEP)
        |=> (state_reg == S_SCAN && step_reg == $past(step_reg) + IDX_W'(1)))
        else $error("scan step did not advance");

    a_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> out_valid_reg)
        else $error("pending result without a held output");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_in == REQ_CLEAR) |=> cnt_reg == '0)
        else $error("clear left entries");
`endif

endmodule

// File: tb/tb_top.sv
// Testbench for the positional ordered list: directed and random requests checked against a local list model.
module tb_top;

    import pol_pkg::*;

    localparam int LIST_CAP     = 16;
    localparam int HALF_PERIOD  = 4;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = LIST_CAP + 8;
    localparam int RANDOM_ITEMS = 1920;
    localparam int GAP_MAX      = 12;

    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [4:0]  found_position;
        logic [4:0]  list_length;
        logic        is_empty;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [31:0]  list_mem [LIST_CAP];
    int           list_len;
    list_result_t pending_results [$];

    int req_gap_max;
    int resp_stall_max;
    int idle_cycles;
    int mismatches;
    int reqs_done;
    int full_hits;
    int badpos_hits;
    int locate_hits;
    int results_seen;

    positional_ordered_list_top #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [1:0] list_insert(input int pos, input logic [31:0] val);
        if (pos < 1 || pos > list_len + 1)
            return STATUS_BADPOS;
        if (list_len >= LIST_CAP)
            return STATUS_FULL;
        for (int k = list_len; k > pos - 1; k--)
            list_mem[k] = list_mem[k - 1];
        list_mem[pos - 1] = val;
        list_len++;
        return STATUS_OK;
    endfunction

    function automatic list_result_t apply_request(input logic [2:0] kind,
                                                   input logic [7:0] pos,
                                                   input logic [31:0] val);
        list_result_t res;
        int           p;
        p = int'(pos);
        res = '0;
        case (kind)
            REQ_INS_POS:  res.status = list_insert(p, val);
            REQ_INS_HEAD: res.status = list_insert(1, val);
            REQ_INS_TAIL: res.status = list_insert(list_len + 1, val);
            REQ_DELETE:
            begin
                if (p < 1 || p > list_len)
                    res.status = STATUS_BADPOS;
                else
                begin
                    res.read_value = list_mem[p - 1];
                    for (int k = p - 1; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k + 1];
                    list_len--;
                end
            end
            REQ_READ:
            begin
                if (p < 1 || p > list_len)
                    res.status = STATUS_BADPOS;
                else
                    res.read_value = list_mem[p - 1];
            end
            REQ_LOCATE:
            begin
                for (int k = 0; k < list_len; k++)
                begin
                    if (list_mem[k] == val && res.found_position == 0)
                        res.found_position = 5'(k + 1);
                end
            end
            REQ_CLEAR:    list_len = 0;
            default:      ;
        endcase
        res.list_length = 5'(list_len);
        res.is_empty    = (list_len == 0);
        if (res.status == STATUS_FULL)
            full_hits++;
        if (res.status == STATUS_BADPOS)
            badpos_hits++;
        if (res.found_position != 0)
            locate_hits++;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            mismatches++;
        end
    endfunction

    task automatic send_req(input logic [2:0] kind, input logic [7:0] pos,
                            input logic [31:0] val);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  = kind;
        s_axis_tdata  = {val, pos};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(apply_request(kind, pos, val));
        reqs_done++;
        @(negedge clk);
    endtask

    task automatic test_empty_list();
        send_req(REQ_READ,    8'd1,   32'h0);
        send_req(REQ_DELETE,  8'd0,   32'h0);
        send_req(REQ_DELETE,  8'd1,   32'h0);
        send_req(REQ_LOCATE,  8'd0,   32'h0);
        send_req(REQ_INS_POS, 8'd0,   32'h1234_5678);
        send_req(REQ_INS_POS, 8'd2,   32'h1234_5678);
        send_req(REQ_UNUSED,  8'hff,  32'hffff_ffff);
        send_req(REQ_CLEAR,   8'd0,   32'h0);
    endtask

    task automatic test_field_extremes();
        send_req(REQ_INS_HEAD, 8'd0,  32'h8000_0000);
        send_req(REQ_INS_TAIL, 8'hff, 32'h7fff_ffff);
        send_req(REQ_INS_POS,  8'd2,  32'hffff_ffff);
        send_req(REQ_INS_POS,  8'hff, 32'h0);
        send_req(REQ_READ,     8'd1,  32'h0);
        send_req(REQ_READ,     8'd3,  32'h0);
        send_req(REQ_READ,     8'd4,  32'h0);
        send_req(REQ_LOCATE,   8'hff, 32'hffff_ffff);
        send_req(REQ_LOCATE,   8'd1,  32'h0);
        send_req(REQ_DELETE,   8'd2,  32'h0);
        send_req(REQ_READ,     8'hff, 32'h0);
    endtask

    task automatic test_full_list();
        send_req(REQ_CLEAR, 8'd0, 32'h0);
        for (int i = 0; i < LIST_CAP; i++)
            send_req(REQ_INS_TAIL, 8'd0, (i == LIST_CAP - 1) ? 32'h5 : 32'(i * 3 + 100));
        send_req(REQ_INS_TAIL, 8'd0,  32'h1);
        send_req(REQ_INS_POS,  8'd0,  32'h1);
        send_req(REQ_INS_HEAD, 8'd0,  32'h1);
        send_req(REQ_LOCATE,   8'd0,  32'h5);
        send_req(REQ_DELETE,   8'(LIST_CAP), 32'h0);
        send_req(REQ_DELETE,   8'd1,  32'h0);
    endtask

    task automatic test_random_mix(input int count);
        logic [31:0] value_pool [8];
        logic [2:0]  kind;
        logic [7:0]  pos;
        logic [31:0] val;
        bit          growing;
        int          r;
        int          mode;
        value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0,
                       32'h1, 32'h55aa_55aa, 32'haa55_aa55, 32'h42};
        growing = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                mode = $urandom_range(0, 3);
                req_gap_max    = (mode == 1 || mode == 2) ? GAP_MAX : 0;
                resp_stall_max = (mode == 1 || mode == 3) ? GAP_MAX : 0;
            end
            if (list_len >= LIST_CAP || $urandom_range(0, 39) == 0)
                growing = 1'b0;
            if (list_len == 0)
                growing = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 1)
                kind = REQ_CLEAR;
            else if (r < 2)
                kind = REQ_UNUSED;
            else if (r < (growing ? 57 : 22))
                kind = 3'($urandom_range(REQ_INS_POS, REQ_INS_TAIL));
            else
                kind = 3'($urandom_range(REQ_DELETE, REQ_LOCATE));
            if ($urandom_range(0, 99) < 12)
                pos = 8'($urandom_range(0, 255));
            else if (kind == REQ_DELETE || kind == REQ_READ)
                pos = 8'($urandom_range(1, (list_len > 0) ? list_len : 1));
            else
                pos = 8'($urandom_range(1, list_len + 1));
            if ($urandom_range(0, 1) == 0)
                val = value_pool[$urandom_range(0, 7)];
            else
                val = $urandom;
            send_req(kind, pos, val);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request outstanding: tdata 0x%0h",
                       m_axis_tdata);
                mismatches++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("status",         32'(exp.status),         32'(m_axis_tuser));
                check_field("read_value",     exp.read_value,          m_axis_tdata[31:0]);
                check_field("found_position", 32'(exp.found_position), 32'(m_axis_tdata[36:32]));
                check_field("list_length",    32'(exp.list_length),    32'(m_axis_tdata[41:37]));
                check_field("is_empty",       32'(exp.is_empty),       32'(m_axis_tdata[42]));
                check_field("tdata padding",  32'h0,                   32'(m_axis_tdata[47:43]));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d results outstanding",
                       STALL_LIMIT, pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : result_side
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, resp_stall_max);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        list_len       = 0;
        req_gap_max    = 3;
        resp_stall_max = 3;
        mismatches     = 0;
        reqs_done      = 0;
        full_hits      = 0;
        badpos_hits    = 0;
        locate_hits    = 0;
        results_seen   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_list();
        test_field_extremes();
        test_full_list();
        test_random_mix(RANDOM_ITEMS);

        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results: %0d full rejections, %0d bad positions,",
                 reqs_done, results_seen, full_hits, badpos_hits);
        $display("%0d successful locates, with sender gaps and receiver stalls up to %0d cycles",
                 locate_hits, GAP_MAX);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
